// ===== rtl/schedule_table_thread_arbiter_core_defines.svh =====
// Assertion macros for the arbiter RTL, used by stta_back.
`ifndef SCHEDULE_TABLE_THREAD_ARBITER_CORE_DEFINES_SVH
`define SCHEDULE_TABLE_THREAD_ARBITER_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define STTA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stta assertion failed");

// next-cycle implication, disabled in reset
`define STTA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stta assertion failed");

`endif

// ===== rtl/stta_pkg.sv =====
// Shared types, constants and helpers for the schedule table thread arbiter.
`timescale 1ns / 1ps

package stta_pkg;

  localparam int THREAD_COUNT = 32;
  localparam int TABLE_DEPTH  = 128;
  localparam int THREAD_W     = 5;
  localparam int INDEX_W      = 7;
  localparam int LEN_W        = 8;
  localparam int COUNT_W      = 16;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [COUNT_W-1:0] LIMIT_RESET = 16'd8192;

  // input function codes
  localparam logic [1:0] FUNC_WRITE  = 2'd0;
  localparam logic [1:0] FUNC_RUN    = 2'd1;
  localparam logic [1:0] FUNC_BLOCK  = 2'd2;
  localparam logic [1:0] FUNC_DECIDE = 2'd3;

  // internal operation codes carried through the queue
  localparam logic [1:0] OP_TABLE_WR = 2'd0;
  localparam logic [1:0] OP_MASK_SET = 2'd1;
  localparam logic [1:0] OP_MASK_CLR = 2'd2;
  localparam logic [1:0] OP_DECIDE   = 2'd3;

  localparam logic [1:0] ERR_OK     = 2'd0;
  localparam logic [1:0] ERR_PREFIX = 2'd1;
  localparam logic [1:0] ERR_LIMIT  = 2'd2;

  localparam logic [1:0] CFG_PREFIX_MODE = 2'd0;
  localparam logic [1:0] CFG_SCHED_LEN   = 2'd1;
  localparam logic [1:0] CFG_DEC_LIMIT   = 2'd2;

  typedef struct packed {
    logic [1:0]              op;
    logic [THREAD_COUNT-1:0] thread_bit;
    logic [INDEX_W-1:0]      index;
    logic [THREAD_W-1:0]     value;
  } req_t;

  function automatic logic [THREAD_W-1:0] lowest_runnable(input logic [THREAD_COUNT-1:0] mask);
    logic [THREAD_W-1:0] res;
    res = '0;
    for (int i = THREAD_COUNT - 1; i >= 0; i--) begin
      if (mask[i]) res = THREAD_W'(i);
    end
    return res;
  endfunction

endpackage

// ===== rtl/schedule_table_thread_arbiter_core.sv =====
// Top level of the schedule table thread arbiter.
//
//  channel  direction  handshake           payload
//  in       sink       in_valid/in_stall   func, thread, entry_index, entry_value
//  out      source     out_valid/out_stall selected_thread, none_runnable,
//                                          runnable_snapshot, decision_number, error_code
//  cfg      sink       cfg_we              cfg_addr, cfg_wdata
//
// Table writes, mask updates and decisions while halted are handled by the back end as it
// pops them from the two-entry queue. A prefix table pick goes through the PREFIX and DONE
// states and a lowest-runnable fallback straight to DONE; a repeating decision stays in SCAN
// over k table entries (1..min(schedule_length, 128)), one table read per cycle, then DONE.
// Reset is synchronous, active low; the table is not cleared, so no clearing pass.
// The front keeps accepting until the queue fills; a stalled result holds the back end
// only when the next decision is ready to report.
`timescale 1ns / 1ps

module schedule_table_thread_arbiter_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_addr,
  input  logic [stta_pkg::COUNT_W-1:0]        cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_func,
  input  logic [stta_pkg::THREAD_W-1:0]       in_thread,
  input  logic [stta_pkg::INDEX_W-1:0]        in_entry_index,
  input  logic [stta_pkg::THREAD_W-1:0]       in_entry_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [stta_pkg::THREAD_W-1:0]       out_selected_thread,
  output logic                                out_none_runnable,
  output logic [stta_pkg::THREAD_COUNT-1:0]   out_runnable_snapshot,
  output logic [stta_pkg::COUNT_W-1:0]        out_decision_number,
  output logic [1:0]                          out_error_code
);

  logic           q_full, q_push, q_pop, q_valid;
  stta_pkg::req_t push_req, pop_req;

  stta_front u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_thread      (in_thread),
    .in_entry_index (in_entry_index),
    .in_entry_value (in_entry_value),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_req          (push_req)
  );

  stta_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_req (push_req),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_req  (pop_req)
  );

  stta_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_addr              (cfg_addr),
    .cfg_wdata             (cfg_wdata),
    .q_valid               (q_valid),
    .q_req                 (pop_req),
    .q_pop                 (q_pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_selected_thread   (out_selected_thread),
    .out_none_runnable     (out_none_runnable),
    .out_runnable_snapshot (out_runnable_snapshot),
    .out_decision_number   (out_decision_number),
    .out_error_code        (out_error_code)
  );

endmodule

// ===== rtl/stta_front.sv =====
// Front end: accepts requests and decodes them into queue entries.
`timescale 1ns / 1ps

module stta_front (
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_func,
  input  logic [stta_pkg::THREAD_W-1:0]   in_thread,
  input  logic [stta_pkg::INDEX_W-1:0]    in_entry_index,
  input  logic [stta_pkg::THREAD_W-1:0]   in_entry_value,
  input  logic                            q_full,
  output logic                            q_push,
  output stta_pkg::req_t                  q_req
);

  logic [1:0] op;

  always_comb begin
    case (in_func)
      stta_pkg::FUNC_WRITE:  op = stta_pkg::OP_TABLE_WR;
      stta_pkg::FUNC_RUN:    op = stta_pkg::OP_MASK_SET;
      stta_pkg::FUNC_BLOCK:  op = stta_pkg::OP_MASK_CLR;
      stta_pkg::FUNC_DECIDE: op = stta_pkg::OP_DECIDE;
      default:               op = stta_pkg::OP_DECIDE;
    endcase
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_req.op         = op;
    // one-hot thread select so the back end does a plain OR / AND-NOT
    q_req.thread_bit = {{(stta_pkg::THREAD_COUNT-1){1'b0}}, 1'b1} << in_thread;
    q_req.index      = in_entry_index;
    q_req.value      = in_entry_value;
  end

endmodule

// ===== rtl/stta_queue.sv =====
// Short request FIFO between the front end and the back end.
`timescale 1ns / 1ps

module stta_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  stta_pkg::req_t push_req,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output stta_pkg::req_t pop_req
);

  localparam int AW = (stta_pkg::QUEUE_DEPTH > 1) ? $clog2(stta_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(stta_pkg::QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(stta_pkg::QUEUE_DEPTH - 1);

  stta_pkg::req_t slot_r [stta_pkg::QUEUE_DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full    = (cnt_r == CW'(stta_pkg::QUEUE_DEPTH));
  assign valid   = (cnt_r != '0);
  assign pop_req = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + AW'(1);
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + AW'(1);
    if (do_push && !do_pop)      cnt_nxt = cnt_r + CW'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_req;
  end

endmodule

// ===== rtl/stta_back.sv =====
// Back end: schedule table, runnable mask, decision sequencer and result register.
`timescale 1ns / 1ps
`include "schedule_table_thread_arbiter_core_defines.svh"

module stta_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_addr,
  input  logic [stta_pkg::COUNT_W-1:0]        cfg_wdata,
  input  logic                                q_valid,
  input  stta_pkg::req_t                      q_req,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [stta_pkg::THREAD_W-1:0]       out_selected_thread,
  output logic                                out_none_runnable,
  output logic [stta_pkg::THREAD_COUNT-1:0]   out_runnable_snapshot,
  output logic [stta_pkg::COUNT_W-1:0]        out_decision_number,
  output logic [1:0]                          out_error_code
);

  localparam int LW = stta_pkg::LEN_W;
  localparam int TW = stta_pkg::THREAD_W;
  localparam int NT = stta_pkg::THREAD_COUNT;
  localparam int CW = stta_pkg::COUNT_W;
  localparam int IW = stta_pkg::INDEX_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_PREFIX = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  function automatic logic [LW-1:0] wrap_next(input logic [LW-1:0] a, input logic [LW-1:0] len);
    logic [LW-1:0] s;
    s = a + LW'(1);
    return (s == len) ? '0 : s;
  endfunction

  logic [TW-1:0] table_mem [stta_pkg::TABLE_DEPTH];
  logic [TW-1:0] rdata_r;
  logic [IW-1:0] rd_addr;

  logic [1:0]    state_r, state_nxt;
  logic [LW-1:0] cursor_r, cursor_nxt;
  logic [NT-1:0] mask_r, mask_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          halted_r, halted_nxt;
  logic          prefix_mode_r;
  logic [LW-1:0] sched_len_r;
  logic [CW-1:0] limit_r;

  logic [NT-1:0] snap_r, snap_nxt;
  logic [TW-1:0] pick_r, pick_nxt;
  logic          none_r, none_nxt;
  logic          perr_r, perr_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] issue_addr_r, issue_addr_nxt;
  logic [LW-1:0] issued_r, issued_nxt;
  logic [LW-1:0] chk_addr_r, chk_addr_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [TW-1:0] out_sel_r, out_sel_nxt;
  logic          out_none_r, out_none_nxt;
  logic [NT-1:0] out_snap_r, out_snap_nxt;
  logic [CW-1:0] out_num_r, out_num_nxt;
  logic [1:0]    out_err_r, out_err_nxt;

  logic [LW-1:0] eff_len;
  logic [LW-1:0] start;
  logic          at_most_one;
  logic          tbl_we;
  logic          out_free;
  logic [1:0]    err;

  assign eff_len     = (sched_len_r > LW'(stta_pkg::TABLE_DEPTH)) ?
                       LW'(stta_pkg::TABLE_DEPTH) : sched_len_r;
  assign at_most_one = ((mask_r & (mask_r - NT'(1))) == '0);
  assign start       = (cursor_r >= eff_len) ? '0 : cursor_r;
  assign out_free    = !out_valid_r || !out_stall;
  assign q_pop       = q_valid && (state_r == ST_IDLE);
  assign tbl_we      = q_pop && (q_req.op == stta_pkg::OP_TABLE_WR);

  always_comb begin
    if (none_r)                 err = stta_pkg::ERR_OK;
    else if (perr_r)            err = stta_pkg::ERR_PREFIX;
    else if (count_r >= limit_r) err = stta_pkg::ERR_LIMIT;
    else                        err = stta_pkg::ERR_OK;
  end

  always_comb begin
    state_nxt      = state_r;
    cursor_nxt     = cursor_r;
    mask_nxt       = mask_r;
    count_nxt      = count_r;
    halted_nxt     = halted_r;
    snap_nxt       = snap_r;
    pick_nxt       = pick_r;
    none_nxt       = none_r;
    perr_nxt       = perr_r;
    len_nxt        = len_r;
    issue_addr_nxt = issue_addr_r;
    issued_nxt     = issued_r;
    chk_addr_nxt   = chk_addr_r;
    rd_addr        = cursor_r[IW-1:0];
    out_valid_nxt  = out_valid_r && out_stall;
    out_sel_nxt    = out_sel_r;
    out_none_nxt   = out_none_r;
    out_snap_nxt   = out_snap_r;
    out_num_nxt    = out_num_r;
    out_err_nxt    = out_err_r;

    case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          case (q_req.op)
            stta_pkg::OP_MASK_SET: mask_nxt = mask_r | q_req.thread_bit;
            stta_pkg::OP_MASK_CLR: mask_nxt = mask_r & ~q_req.thread_bit;
            stta_pkg::OP_DECIDE: begin
              if (!halted_r) begin
                snap_nxt = mask_r;
                perr_nxt = 1'b0;
                none_nxt = 1'b0;
                if (prefix_mode_r) begin
                  if (at_most_one || (cursor_r >= eff_len)) begin
                    pick_nxt  = stta_pkg::lowest_runnable(mask_r);
                    none_nxt  = (mask_r == '0);
                    state_nxt = ST_DONE;
                  end else begin
                    rd_addr    = cursor_r[IW-1:0];
                    cursor_nxt = cursor_r + LW'(1);
                    state_nxt  = ST_PREFIX;
                  end
                end else if (eff_len == '0) begin
                  pick_nxt  = stta_pkg::lowest_runnable(mask_r);
                  none_nxt  = (mask_r == '0);
                  state_nxt = ST_DONE;
                end else begin
                  // first read of the scan goes out now; check runs next cycle
                  rd_addr        = start[IW-1:0];
                  chk_addr_nxt   = start;
                  issue_addr_nxt = wrap_next(start, eff_len);
                  issued_nxt     = LW'(1);
                  len_nxt        = eff_len;
                  state_nxt      = ST_SCAN;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_PREFIX: begin
        pick_nxt  = rdata_r;
        perr_nxt  = !mask_r[rdata_r];
        state_nxt = ST_DONE;
      end
      ST_SCAN: begin
        if (mask_r[rdata_r]) begin
          pick_nxt   = rdata_r;
          cursor_nxt = wrap_next(chk_addr_r, len_r);
          state_nxt  = ST_DONE;
        end else if (issued_r == len_r) begin
          // whole table missed: cursor is back where the scan began
          pick_nxt   = stta_pkg::lowest_runnable(mask_r);
          none_nxt   = (mask_r == '0);
          cursor_nxt = wrap_next(chk_addr_r, len_r);
          state_nxt  = ST_DONE;
        end else begin
          rd_addr        = issue_addr_r[IW-1:0];
          chk_addr_nxt   = issue_addr_r;
          issue_addr_nxt = wrap_next(issue_addr_r, len_r);
          issued_nxt     = issued_r + LW'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_sel_nxt   = none_r ? '0 : pick_r;
          out_none_nxt  = none_r;
          out_snap_nxt  = snap_r;
          out_num_nxt   = count_r;
          out_err_nxt   = err;
          if (err != stta_pkg::ERR_OK) halted_nxt = 1'b1;
          else if (!none_r)            count_nxt  = count_r + CW'(1);
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cursor_r      <= '0;
      mask_r        <= '0;
      count_r       <= '0;
      halted_r      <= 1'b0;
      out_valid_r   <= 1'b0;
      prefix_mode_r <= 1'b0;
      sched_len_r   <= '0;
      limit_r       <= stta_pkg::LIMIT_RESET;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      mask_r      <= mask_nxt;
      count_r     <= count_nxt;
      halted_r    <= halted_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          stta_pkg::CFG_PREFIX_MODE: prefix_mode_r <= cfg_wdata[0];
          stta_pkg::CFG_SCHED_LEN:   sched_len_r   <= cfg_wdata[LW-1:0];
          stta_pkg::CFG_DEC_LIMIT:   limit_r       <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    snap_r       <= snap_nxt;
    pick_r       <= pick_nxt;
    none_r       <= none_nxt;
    perr_r       <= perr_nxt;
    len_r        <= len_nxt;
    issue_addr_r <= issue_addr_nxt;
    issued_r     <= issued_nxt;
    chk_addr_r   <= chk_addr_nxt;
    out_sel_r    <= out_sel_nxt;
    out_none_r   <= out_none_nxt;
    out_snap_r   <= out_snap_nxt;
    out_num_r    <= out_num_nxt;
    out_err_r    <= out_err_nxt;
  end

  // schedule table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (tbl_we) table_mem[q_req.index] <= q_req.value;
    rdata_r <= table_mem[rd_addr];
  end

  assign out_valid             = out_valid_r;
  assign out_selected_thread   = out_sel_r;
  assign out_none_runnable     = out_none_r;
  assign out_runnable_snapshot = out_snap_r;
  assign out_decision_number   = out_num_r;
  assign out_error_code        = out_err_r;

  `STTA_ASSERT_IMPL(a_pop_only_idle, clk, rst_n, state_r != ST_IDLE, !q_pop)
  `STTA_ASSERT_NEXT(a_halt_sticky, clk, rst_n, halted_r, halted_r)
  `STTA_ASSERT_IMPL(a_none_clean, clk, rst_n, out_valid_r && out_none_r,
                    (out_sel_r == '0) && (out_err_r == stta_pkg::ERR_OK))
  `STTA_ASSERT_IMPL(a_scan_bound, clk, rst_n, state_r == ST_SCAN,
                    (issued_r <= len_r) && (chk_addr_r < len_r))

endmodule

// ===== tb/tb_schedule_table_thread_arbiter_core.sv =====
// Self-checking testbench for the schedule table thread arbiter core.
`timescale 1ns / 1ps

module tb_schedule_table_thread_arbiter_core;
  import stta_pkg::*;

  localparam int DRAIN_CYCLES = 160;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [1:0]          func;
    logic [THREAD_W-1:0] thread;
    logic [INDEX_W-1:0]  index;
    logic [THREAD_W-1:0] value;
  } arb_req_t;

  typedef struct packed {
    logic [THREAD_W-1:0]     thread;
    logic                    no_thread;
    logic [THREAD_COUNT-1:0] snap;
    logic [COUNT_W-1:0]      number;
    logic [1:0]              err;
  } pick_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [1:0]              cfg_addr = CFG_PREFIX_MODE;
  logic [COUNT_W-1:0]      cfg_wdata = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [1:0]              in_func = FUNC_WRITE;
  logic [THREAD_W-1:0]     in_thread = '0;
  logic [INDEX_W-1:0]      in_entry_index = '0;
  logic [THREAD_W-1:0]     in_entry_value = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [THREAD_W-1:0]     out_selected_thread;
  logic                    out_none_runnable;
  logic [THREAD_COUNT-1:0] out_runnable_snapshot;
  logic [COUNT_W-1:0]      out_decision_number;
  logic [1:0]              out_error_code;

  // arbiter model state and register copies
  logic [THREAD_W-1:0]     sched_tbl [TABLE_DEPTH];
  int unsigned             cursor_m = 0;
  logic [THREAD_COUNT-1:0] run_mask = '0;
  logic [COUNT_W-1:0]      pick_count = '0;
  bit                      halted_m = 1'b0;
  bit                      prefix_on = 1'b0;
  int unsigned             sched_len = 0;
  logic [COUNT_W-1:0]      pick_limit = LIMIT_RESET;

  arb_req_t    pending_reqs[$];
  pick_t       expected_picks[$];
  arb_req_t    cur_req;
  int unsigned fail_count = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  bit          send_idle = 1'b1;
  bit          recv_idle = 1'b1;
  bit          hold_req = 1'b0;
  bit          hold_ack = 1'b0;
  int unsigned hold_left = 0;
  int unsigned len_choices [12] = '{0, 1, 2, 3, 5, 8, 31, 64, 127, 128, 200, 255};

  schedule_table_thread_arbiter_core u_dut (
    .clk,
    .rst_n,
    .cfg_we,
    .cfg_addr,
    .cfg_wdata,
    .in_valid,
    .in_stall,
    .in_func,
    .in_thread,
    .in_entry_index,
    .in_entry_value,
    .out_valid,
    .out_stall,
    .out_selected_thread,
    .out_none_runnable,
    .out_runnable_snapshot,
    .out_decision_number,
    .out_error_code
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one accepted request to the model; a decision while not halted queues its expected pick.
  task automatic arbitrate(input arb_req_t r);
    pick_t               p;
    int unsigned         len;
    bit                  found;
    bit                  bad;
    logic [THREAD_W-1:0] cand;
    int                  n;
    int                  t;
    case (r.func)
      FUNC_WRITE: sched_tbl[r.index] = r.value;
      FUNC_RUN:   run_mask[r.thread] = 1'b1;
      FUNC_BLOCK: run_mask[r.thread] = 1'b0;
      default: begin
        if (!halted_m) begin
          len = (sched_len > TABLE_DEPTH) ? TABLE_DEPTH : sched_len;
          found = 1'b0;
          bad = 1'b0;
          cand = '0;
          p.snap = run_mask;
          p.number = pick_count;
          if (prefix_on) begin
            if ($countones(run_mask) > 1 && cursor_m < len) begin
              cand = sched_tbl[cursor_m];
              cursor_m++;
              found = 1'b1;
              bad = !run_mask[cand];
            end
          end else begin
            // stale cursor restarts the cyclic scan at entry 0
            if (len != 0 && cursor_m >= len) cursor_m = 0;
            for (n = 0; n < len && !found; n++) begin
              cand = sched_tbl[cursor_m];
              cursor_m = (cursor_m + 1) % len;
              found = run_mask[cand];
            end
          end
          if (!found) begin
            for (t = THREAD_COUNT - 1; t >= 0; t--) begin
              if (run_mask[t]) begin
                cand = THREAD_W'(t);
                found = 1'b1;
              end
            end
          end
          if (!found) begin
            p.thread = '0;
            p.no_thread = 1'b1;
            p.err = ERR_OK;
          end else begin
            p.thread = cand;
            p.no_thread = 1'b0;
            if (bad) begin
              p.err = ERR_PREFIX;
              halted_m = 1'b1;
            end else if (pick_count >= pick_limit) begin
              p.err = ERR_LIMIT;
              halted_m = 1'b1;
            end else begin
              p.err = ERR_OK;
              pick_count++;
            end
          end
          expected_picks.push_back(p);
        end
      end
    endcase
  endtask

  task automatic push_req(input logic [1:0] f, input int unsigned thr,
                          input int unsigned idx, input int unsigned val);
    arb_req_t r;
    r.func = f;
    r.thread = THREAD_W'(thr);
    r.index = INDEX_W'(idx);
    r.value = THREAD_W'(val);
    pending_reqs.push_back(r);
  endtask

  task automatic wait_accepted();
    do @(negedge clk); while (pending_reqs.size() != 0 || in_valid);
  endtask

  task automatic settle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_picks.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic configure(input bit mode, input int unsigned len, input int unsigned limit);
    settle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_PREFIX_MODE;
    cfg_wdata <= COUNT_W'(mode);
    @(posedge clk);
    cfg_addr <= CFG_SCHED_LEN;
    cfg_wdata <= COUNT_W'(len);
    @(posedge clk);
    cfg_addr <= CFG_DEC_LIMIT;
    cfg_wdata <= COUNT_W'(limit);
    @(posedge clk);
    cfg_we <= 1'b0;
    prefix_on = mode;
    sched_len = len & 8'hFF;
    pick_limit = COUNT_W'(limit);
    @(negedge clk);
  endtask

  // In prefix mode a decision must not land on a blocked entry before the end,
  // so make that entry runnable first.
  task automatic push_decide();
    int unsigned len;
    if (prefix_on) begin
      wait_accepted();
      len = (sched_len > TABLE_DEPTH) ? TABLE_DEPTH : sched_len;
      if ($countones(run_mask) > 1 && cursor_m < len && !run_mask[sched_tbl[cursor_m]])
        push_req(FUNC_RUN, 32'(sched_tbl[cursor_m]), $urandom, $urandom);
    end
    push_req(FUNC_DECIDE, $urandom, $urandom, $urandom);
  endtask

  task automatic push_random(input int unsigned decide_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < decide_pct)
      push_decide();
    else if (r < decide_pct + (100 - decide_pct) / 5)
      push_req(FUNC_WRITE, $urandom, $urandom, $urandom);
    else if ($urandom_range(0, 1) == 0)
      push_req(FUNC_RUN, $urandom, $urandom, $urandom);
    else
      push_req(FUNC_BLOCK, $urandom, $urandom, $urandom);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) arbitrate(cur_req);
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          cur_req = pending_reqs.pop_front();
          in_func <= cur_req.func;
          in_thread <= cur_req.thread;
          in_entry_index <= cur_req.index;
          in_entry_value <= cur_req.value;
          in_valid <= 1'b1;
          send_gap = send_idle ? $urandom_range(0, 17) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, started by toggling hold_req
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    pick_t got;
    pick_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_selected_thread, out_none_runnable, out_runnable_snapshot,
               out_decision_number, out_error_code};
        if (expected_picks.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: thread %0d none %0b mask %h number %0d err %0d",
                     got.thread, got.no_thread, got.snap, got.number, got.err);
        end else begin
          want = expected_picks.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected thread %0d none %0b mask %h number %0d err %0d, %s",
                       want.thread, want.no_thread, want.snap, want.number, want.err,
                       $sformatf("got thread %0d none %0b mask %h number %0d err %0d",
                                 got.thread, got.no_thread, got.snap, got.number, got.err));
          end
        end
        recv_gap = recv_idle ? $urandom_range(0, 17) : 0;
      end else if (recv_gap != 0) begin
        recv_gap--;
      end
      out_stall <= (recv_gap != 0) || (hold_left != 0);
    end
  end

  initial begin
    #4000000;
    $display("tb_schedule_table_thread_arbiter_core failed");
    $finish;
  end

  initial begin
    int                  i;
    int                  phase;
    int unsigned         len;
    int unsigned         limit;
    bit                  mode;
    bit                  prefix_path;
    logic [THREAD_W-1:0] victim;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // load every entry so no decision ever reads an unwritten one
    for (i = 0; i < TABLE_DEPTH; i++) push_req(FUNC_WRITE, $urandom, i, $urandom);
    configure(1'b0, 0, 32'(LIMIT_RESET));

    // empty length: lowest runnable or none
    push_req(FUNC_DECIDE, 31, 127, 31);
    push_req(FUNC_RUN, 0, 127, 31);
    push_req(FUNC_RUN, 31, 0, 0);
    push_decide();
    push_req(FUNC_BLOCK, 0, 127, 31);
    push_decide();
    push_req(FUNC_BLOCK, 31, 0, 0);
    push_decide();

    // prefix: single runnable, two table picks, then prefix used up
    configure(1'b1, 2, 32'hFFFF);
    push_req(FUNC_RUN, 7, 0, 0);
    push_decide();
    wait_accepted();
    push_req(FUNC_RUN, 32'(sched_tbl[0]), 0, 0);
    push_req(FUNC_RUN, 32'(sched_tbl[1]), 0, 0);
    push_req(FUNC_RUN, 32'(sched_tbl[0] ^ 5'd1), 0, 0);
    push_decide();
    push_decide();
    push_decide();

    // cursor now beyond a shorter repeating table
    configure(1'b0, 1, 32'(LIMIT_RESET));
    push_decide();
    push_decide();

    for (phase = 0; phase < 8; phase++) begin
      mode = (phase == 3) ? 1'b0 : ($urandom_range(0, 2) == 0);
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                        : len_choices[$urandom_range(0, 11)];
      limit = ($urandom_range(0, 3) == 0) ? 16'hFFFF : $urandom_range(2000, 65535);
      configure(mode, len, limit);
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      if (phase == 3) begin
        // receiver holds off while requests keep coming
        send_idle = 1'b0;
        hold_req = !hold_req;
      end
      repeat (75) push_random((phase == 3) ? 60 : 35);
    end

    // end with one halting error, then check that decisions stay silent
    prefix_path = $urandom_range(0, 1);
    send_idle = 1'b1;
    recv_idle = 1'b1;
    configure(prefix_path, 128, 1);
    if (prefix_path && cursor_m < TABLE_DEPTH) begin
      victim = sched_tbl[cursor_m];
      push_req(FUNC_BLOCK, 32'(victim), $urandom, $urandom);
      push_req(FUNC_RUN, 32'(victim ^ 5'd1), $urandom, $urandom);
      push_req(FUNC_RUN, 32'(victim ^ 5'd2), $urandom, $urandom);
    end else begin
      push_req(FUNC_RUN, $urandom, $urandom, $urandom);
    end
    push_req(FUNC_DECIDE, $urandom, $urandom, $urandom);
    repeat (25) push_req(2'($urandom), $urandom, $urandom, $urandom);
    push_req(FUNC_RUN, 3, 0, 0);
    push_req(FUNC_DECIDE, 0, 0, 0);

    settle();
    if (fail_count == 0 && expected_picks.size() == 0)
      $display("tb_schedule_table_thread_arbiter_core passed");
    else
      $display("tb_schedule_table_thread_arbiter_core failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/stta_pkg.sv
rtl/stta_front.sv
rtl/stta_queue.sv
rtl/stta_back.sv
rtl/schedule_table_thread_arbiter_core.sv
tb/tb_schedule_table_thread_arbiter_core.sv
